// ----- rtl/odo_pkg.sv -----
`timescale 1ns / 1ps
package odo_pkg;

	// default precision of the cos/sin unit
	localparam int TRIG_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [1:0] REG_LEFT_DPT  = 2'd0;
	localparam logic [1:0] REG_RIGHT_DPT = 2'd1;
	localparam logic [1:0] REG_HEAD_PM   = 2'd2;

	// configuration reset values
	localparam logic [31:0] LEFT_DPT_RST  = 32'd329418;
	localparam logic [31:0] RIGHT_DPT_RST = 32'd329418;
	localparam logic [39:0] HEAD_PM_RST   = 40'd2278541500;

	// input commands
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// CORDIC gain 0.607252935 in Q0.32
	localparam longint CORDIC_GAIN_Q32 = 64'd2608131496;

	// arctan(2^-i) as a fraction of one turn, Q0.32
	localparam logic [31:0] ATAN_TURN [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic               cmd;
		logic [31:0]        left_count;
		logic [31:0]        right_count;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic [15:0]        start_heading;
	} odo_sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
	} odo_pose_t;

endpackage

// ----- rtl/odo_mul.sv -----
`timescale 1ns / 1ps
module odo_mul import odo_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);

	// shared signed multiplier, product registered
	logic signed [65:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ----- rtl/odo_cordic.sv -----
`timescale 1ns / 1ps
module odo_cordic import odo_pkg::*; #(
	parameter int TRIG_BITS = TRIG_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [15:0]              angle,
	output logic                     done,
	output logic signed [TRIG_BITS+2:0] cos_val,
	output logic signed [TRIG_BITS+2:0] sin_val
);

	localparam int     VW = TRIG_BITS + 3;
	localparam longint XG = (CORDIC_GAIN_Q32 + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS);
	localparam logic signed [VW-1:0] X_INIT = VW'(XG);
	localparam logic [4:0] LAST = 5'(TRIG_BITS - 1);

	logic signed [VW-1:0] x_q, y_q, xs, ys;
	logic signed [33:0]   z_q, at;
	logic [4:0]           i_q;
	logic                 run_q, flip_q, done_q;
	logic                 flip;
	logic [15:0]          a16;

	// fold the left half plane onto the right one
	assign flip = angle[15] ^ angle[14];
	assign a16  = flip ? (angle ^ 16'h8000) : angle;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({2'b00, ATAN_TURN[i_q]});

	// one rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= 5'd0;
			end else if (run_q) begin
				if (i_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= X_INIT;
			y_q    <= '0;
			z_q    <= 34'($signed({a16, 16'h0000}));
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

// ----- rtl/diff_drive_odometry_integrator_unit.sv -----
`timescale 1ns / 1ps
// Differential-drive odometry integrator, midpoint rule, fixed point.
// sample/sample_valid/sample_ready take one request: cmd start loads the
// pose and encoder references, cmd sample integrates one encoder reading.
// pose/pose_valid/pose_ready return one pose per request.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the per-tick distances and
// the heading scale; cfg_ready is always high, index 3 is ignored.
// A start request goes straight to the output load. A sample request makes
// nine passes through the one shared 33x33 multiplier, with a CORDIC load
// and its rotations, one per cycle, part way through, then the final update
// and the output load. One request is in flight at a time and the input
// reopens the cycle after the output load, so a new request is taken only
// once the last one is through.
// The finished pose sits in an output register; a new request is accepted
// while it waits. If the receiver stalls, the next pose is held inside
// and sample_ready stays low until the output register frees.
// Reset clears the pose, heading and references and loads the default
// configuration.
module diff_drive_odometry_integrator_unit import odo_pkg::*; #(
	parameter int TRIG_BITS = TRIG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  odo_sample_t sample,
	output logic        pose_valid,
	input  logic        pose_ready,
	output odo_pose_t   pose,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	localparam int VW = TRIG_BITS + 3;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MULA = 3'd1;
	localparam logic [2:0] S_CST  = 3'd2;
	localparam logic [2:0] S_CORD = 3'd3;
	localparam logic [2:0] S_MULB = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [3:0] OP_SL  = 4'd0;
	localparam logic [3:0] OP_SR  = 4'd1;
	localparam logic [3:0] OP_PLL = 4'd2;
	localparam logic [3:0] OP_PLH = 4'd3;
	localparam logic [3:0] OP_PHL = 4'd4;
	localparam logic [3:0] OP_XL  = 4'd5;
	localparam logic [3:0] OP_XH  = 4'd6;
	localparam logic [3:0] OP_YL  = 4'd7;
	localparam logic [3:0] OP_YH  = 4'd8;

	localparam logic signed [48:0] DS_HI = 49'sd137438953472;
	localparam logic signed [48:0] DS_LO = -49'sd137438953472;
	localparam logic signed [71:0] RND   = 72'sd1 <<< (TRIG_BITS - 1);
	localparam logic signed [71:0] SMAX  = 72'sd2147483647;
	localparam logic signed [71:0] SMIN  = -72'sd2147483648;

	logic [2:0]  state_q;
	logic [3:0]  op_q;
	logic        ph_q;
	logic [31:0] ldpt_q, rdpt_q;
	logic [39:0] hpm_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0] hd_q;
	logic [31:0] last_l_q, last_r_q, dl_q, dr_q;
	logic signed [47:0] sl_q, sr_q;
	logic [63:0] p_q;
	logic signed [71:0] mx_q, my_q;
	odo_pose_t   pose_q;
	logic        pose_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic        cord_start, cord_done;
	logic signed [VW-1:0] cos_v, sin_v;

	logic signed [48:0] diff, ssum;
	logic signed [47:0] ds_raw;
	logic signed [38:0] ds;
	logic [63:0] p_rnd, ph_rnd;
	logic [15:0] dth, half;
	logic signed [71:0] dx, dy, nx, ny;
	logic        accept, load_out;

	assign accept       = sample_valid && sample_ready;
	assign sample_ready = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign load_out     = (state_q == S_OUT) && (!pose_valid_q || pose_ready);

	// wheel difference, mean travel clamped
	assign diff   = 49'(sr_q) - 49'(sl_q);
	assign ssum   = 49'(sl_q) + 49'(sr_q);
	assign ds_raw = ssum[48:1];
	always_comb begin
		if (49'(ds_raw) > DS_HI)
			ds = 39'(DS_HI);
		else if (49'(ds_raw) < DS_LO)
			ds = 39'(DS_LO);
		else
			ds = ds_raw[38:0];
	end

	// heading change and half change, rounded
	assign p_rnd  = p_q + 64'h80000000;
	assign ph_rnd = {1'b0, p_q[63:1]} + 64'h80000000;
	assign dth    = p_rnd[47:32];
	assign half   = ph_rnd[47:32];

	// operand select for the shared multiplier
	always_comb begin
		case (op_q)
			OP_SL: begin
				mul_a = $signed({dl_q[31], dl_q});
				mul_b = $signed({1'b0, ldpt_q});
			end
			OP_SR: begin
				mul_a = $signed({dr_q[31], dr_q});
				mul_b = $signed({1'b0, rdpt_q});
			end
			OP_PLL: begin
				mul_a = $signed({1'b0, diff[31:0]});
				mul_b = $signed({1'b0, hpm_q[31:0]});
			end
			OP_PLH: begin
				mul_a = $signed({1'b0, diff[31:0]});
				mul_b = $signed({25'd0, hpm_q[39:32]});
			end
			OP_PHL: begin
				mul_a = 33'($signed(diff[48:32]));
				mul_b = $signed({1'b0, hpm_q[31:0]});
			end
			OP_XL: begin
				mul_a = $signed({1'b0, ds[31:0]});
				mul_b = 33'(cos_v);
			end
			OP_XH: begin
				mul_a = 33'($signed(ds[38:32]));
				mul_b = 33'(cos_v);
			end
			OP_YL: begin
				mul_a = $signed({1'b0, ds[31:0]});
				mul_b = 33'(sin_v);
			end
			OP_YH: begin
				mul_a = 33'($signed(ds[38:32]));
				mul_b = 33'(sin_v);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	odo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign cord_start = (state_q == S_CST);

	odo_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.angle   (hd_q + half),
		.done    (cord_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// position update with rounding and saturation
	assign dx = (mx_q + RND) >>> TRIG_BITS;
	assign dy = (my_q + RND) >>> TRIG_BITS;
	assign nx = 72'(x_q) + dx;
	assign ny = 72'(y_q) + dy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldpt_q <= LEFT_DPT_RST;
			rdpt_q <= RIGHT_DPT_RST;
			hpm_q  <= HEAD_PM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEFT_DPT:  ldpt_q <= cfg_data[31:0];
				REG_RIGHT_DPT: rdpt_q <= cfg_data[31:0];
				REG_HEAD_PM:   hpm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_SL;
			ph_q     <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			hd_q     <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_l_q <= sample.left_count;
						last_r_q <= sample.right_count;
						if (sample.cmd == CMD_START) begin
							x_q     <= sample.start_x;
							y_q     <= sample.start_y;
							hd_q    <= sample.start_heading;
							state_q <= S_OUT;
						end else begin
							op_q    <= OP_SL;
							ph_q    <= 1'b0;
							state_q <= S_MULA;
						end
					end
				end
				S_MULA, S_MULB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						op_q <= op_q + 4'd1;
						if (op_q == OP_PHL)
							state_q <= S_CST;
						else if (op_q == OP_YH)
							state_q <= S_FIN;
					end
				end
				S_CST: state_q <= S_CORD;
				S_CORD: begin
					if (cord_done) begin
						op_q    <= OP_XL;
						ph_q    <= 1'b0;
						state_q <= S_MULB;
					end
				end
				S_FIN: begin
					x_q     <= (nx > SMAX) ? 32'sh7FFFFFFF : (nx < SMIN) ? 32'sh80000000 : nx[31:0];
					y_q     <= (ny > SMAX) ? 32'sh7FFFFFFF : (ny < SMIN) ? 32'sh80000000 : ny[31:0];
					hd_q    <= hd_q + dth;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dl_q <= sample.left_count - last_l_q;
			dr_q <= sample.right_count - last_r_q;
		end
		if ((state_q == S_MULA || state_q == S_MULB) && ph_q) begin
			case (op_q)
				OP_SL:  sl_q <= mul_p[63:16];
				OP_SR:  sr_q <= mul_p[63:16];
				OP_PLL: p_q  <= mul_p[63:0];
				OP_PLH: p_q  <= p_q + {mul_p[31:0], 32'd0};
				OP_PHL: p_q  <= p_q + {mul_p[31:0], 32'd0};
				OP_XL:  mx_q <= 72'(mul_p);
				OP_XH:  mx_q <= mx_q + (72'(mul_p) <<< 32);
				OP_YL:  my_q <= 72'(mul_p);
				OP_YH:  my_q <= my_q + (72'(mul_p) <<< 32);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (load_out) begin
			pose_valid_q <= 1'b1;
		end else if (pose_ready) begin
			pose_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pose_q.pos_x   <= x_q;
			pose_q.pos_y   <= y_q;
			pose_q.heading <= hd_q;
		end
	end

	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;

endmodule
